[src/pras_pkg.sv]
// Shared types and constants of the pyro recovery arming sequencer.
package pras_pkg;

  localparam int unsigned MvW      = 16;
  localparam int unsigned GainW    = 12;
  localparam int unsigned TicksW   = 8;
  localparam int unsigned ResW     = 16;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;
  localparam int unsigned ProdW    = MvW + GainW;      // gained voltage, mV * 1024
  localparam int unsigned ScaleW   = 15;               // width of the resistance scale
  localparam int unsigned NumW     = ProdW + ScaleW;   // dividend of the resistance divide
  localparam int unsigned QuotW    = 18;               // quotient bits kept before saturation
  localparam int unsigned DivW     = ProdW + QuotW - 1; // divisor after the first alignment
  localparam int unsigned DivCntW  = $clog2(QuotW);
  localparam int unsigned StatusW  = 2;
  localparam int unsigned ModeW    = 3;

  localparam logic [ScaleW-1:0] ResScale     = ScaleW'(28000);
  localparam logic [ResW:0]     WireMilliohm = (ResW+1)'(680);
  localparam logic [ProdW-1:0]  LimFireTest  = ProdW'(307200);
  localparam logic [ProdW-1:0]  LimDiagHigh  = ProdW'(3379200);
  localparam logic [ProdW-1:0]  LimCharged   = ProdW'(8192000);

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgSquibGainDiag  = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgPyroGainDiag   = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgSquibGainArm   = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgPyroGainArm    = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgDiagFaultTicks = 3'd4;
  localparam logic [CfgIdxW-1:0] CfgChrgFaultTicks = 3'd5;
  localparam logic [CfgIdxW-1:0] CfgResMin         = 3'd6;
  localparam logic [CfgIdxW-1:0] CfgResMax         = 3'd7;

  localparam logic [GainW-1:0]  RstSquibGain  = GainW'(1126);
  localparam logic [GainW-1:0]  RstPyroGain   = GainW'(1155);
  localparam logic [TicksW-1:0] RstDiagTicks  = TicksW'(10);
  localparam logic [TicksW-1:0] RstChrgTicks  = TicksW'(30);
  localparam logic [ResW-1:0]   RstResMin     = ResW'(1000);
  localparam logic [ResW-1:0]   RstResMax     = ResW'(8500);

  localparam logic [StatusW-1:0] StatusDisarmed = 2'd0;
  localparam logic [StatusW-1:0] StatusOk       = 2'd1;
  localparam logic [StatusW-1:0] StatusFail     = 2'd2;

  typedef struct packed {
    logic [GainW-1:0]  squib_gain_diag;
    logic [GainW-1:0]  pyro_gain_diag;
    logic [GainW-1:0]  squib_gain_arm;
    logic [GainW-1:0]  pyro_gain_arm;
    logic [TicksW-1:0] diag_fault_ticks;
    logic [TicksW-1:0] charge_fault_ticks;
    logic [ResW-1:0]   res_min_milliohm;
    logic [ResW-1:0]   res_max_milliohm;
  } cfg_t;

  typedef struct packed {
    logic load;
    logic mul;
    logic scale;
    logic setup;
    logic div_step;
    logic cmp;
    logic commit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic p_gt_fire;
    logic p_gt_diag;
    logic p_lt_charged;
    logic res_bad;
  } arith_status_t;

endpackage

[src/pras_if.sv]
// Valid/ready channels carrying one tick in and one result beat out.
interface pras_in_if;
  import pras_pkg::*;
  logic            valid;
  logic            ready;
  logic [MvW-1:0]  squib_mv;
  logic [MvW-1:0]  pyro_mv;
  logic            disarm_request;
  logic            launch;

  modport source (output valid, output squib_mv, output pyro_mv,
                  output disarm_request, output launch, input ready);
  modport sink   (input valid, input squib_mv, input pyro_mv,
                  input disarm_request, input launch, output ready);
endinterface

interface pras_out_if;
  import pras_pkg::*;
  logic               valid;
  logic               ready;
  logic               fire_drive;
  logic               charge_drive;
  logic               diag_drive;
  logic               arm_led;
  logic [StatusW-1:0] status_code;
  logic [ModeW-1:0]   mode_now;
  logic               charge_low_alarm;
  logic               resistance_warning;

  modport source (output valid, output fire_drive, output charge_drive,
                  output diag_drive, output arm_led, output status_code,
                  output mode_now, output charge_low_alarm,
                  output resistance_warning, input ready);
  modport sink   (input valid, input fire_drive, input charge_drive,
                  input diag_drive, input arm_led, input status_code,
                  input mode_now, input charge_low_alarm,
                  input resistance_warning, output ready);
endinterface

[src/pras_cfg.sv]
// Configuration register file of the arming sequencer.
module pras_cfg (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [pras_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [pras_pkg::CfgDataW-1:0] cfg_wdata_i,
  output pras_pkg::cfg_t             cfg_o
);
  import pras_pkg::*;

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgSquibGainDiag:  cfg_d.squib_gain_diag    = cfg_wdata_i[GainW-1:0];
        CfgPyroGainDiag:   cfg_d.pyro_gain_diag     = cfg_wdata_i[GainW-1:0];
        CfgSquibGainArm:   cfg_d.squib_gain_arm     = cfg_wdata_i[GainW-1:0];
        CfgPyroGainArm:    cfg_d.pyro_gain_arm      = cfg_wdata_i[GainW-1:0];
        CfgDiagFaultTicks: cfg_d.diag_fault_ticks   = cfg_wdata_i[TicksW-1:0];
        CfgChrgFaultTicks: cfg_d.charge_fault_ticks = cfg_wdata_i[TicksW-1:0];
        CfgResMin:         cfg_d.res_min_milliohm   = cfg_wdata_i[ResW-1:0];
        CfgResMax:         cfg_d.res_max_milliohm   = cfg_wdata_i[ResW-1:0];
        default:           cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.squib_gain_diag    <= RstSquibGain;
      cfg_q.pyro_gain_diag     <= RstPyroGain;
      cfg_q.squib_gain_arm     <= RstSquibGain;
      cfg_q.pyro_gain_arm      <= RstPyroGain;
      cfg_q.diag_fault_ticks   <= RstDiagTicks;
      cfg_q.charge_fault_ticks <= RstChrgTicks;
      cfg_q.res_min_milliohm   <= RstResMin;
      cfg_q.res_max_milliohm   <= RstResMax;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

[src/pras_arith.sv]
// Arithmetic datapath: gained voltages, voltage limits and the resistance divide.
module pras_arith (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  pras_pkg::ctrl_cmd_t      cmd_i,
  input  pras_pkg::cfg_t           cfg_i,
  input  logic                     arm_gains_i,
  input  logic [pras_pkg::MvW-1:0] squib_mv_i,
  input  logic [pras_pkg::MvW-1:0] pyro_mv_i,
  output pras_pkg::arith_status_t  status_o
);
  import pras_pkg::*;

  logic [MvW-1:0]   squib_q, pyro_q;
  logic [ProdW-1:0] s_q, p_q;
  logic [NumW-1:0]  n_q, rem_q, rem_d;
  logic [DivW-1:0]  dvs_q;
  logic [QuotW-1:0] quo_q;
  logic             ovf_q, bad_q;
  logic [GainW-1:0] gain_s, gain_p;
  logic             fits;
  logic [ResW:0]    lo_lim, hi_lim;

  assign gain_s = arm_gains_i ? cfg_i.squib_gain_arm : cfg_i.squib_gain_diag;
  assign gain_p = arm_gains_i ? cfg_i.pyro_gain_arm  : cfg_i.pyro_gain_diag;

  // Restoring step: subtract the aligned divisor where it fits
  assign fits  = ({{(DivW-NumW){1'b0}}, rem_q} >= dvs_q);
  assign rem_d = rem_q - dvs_q[NumW-1:0];

  assign lo_lim = {1'b0, cfg_i.res_min_milliohm} + WireMilliohm;
  assign hi_lim = {1'b0, cfg_i.res_max_milliohm} + WireMilliohm;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bad_q <= 1'b0;
    end else if (cmd_i.cmp) begin
      bad_q <= ovf_q || (quo_q < QuotW'(lo_lim)) || (quo_q > QuotW'(hi_lim));
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      squib_q <= squib_mv_i;
      pyro_q  <= pyro_mv_i;
    end
    if (cmd_i.mul) begin
      s_q <= ProdW'(squib_q) * ProdW'(gain_s);
      p_q <= ProdW'(pyro_q) * ProdW'(gain_p);
    end
    if (cmd_i.scale) begin
      n_q <= NumW'(s_q) * NumW'(ResScale);
    end
    if (cmd_i.setup) begin
      // Quotient at or above 2^QuotW (or zero pyro voltage) saturates as out of range
      ovf_q <= ({{(QuotW+ProdW-NumW){1'b0}}, n_q} >= {p_q, {QuotW{1'b0}}});
      rem_q <= n_q;
      dvs_q <= {p_q, {(QuotW-1){1'b0}}};
      quo_q <= '0;
    end
    if (cmd_i.div_step) begin
      if (fits) begin
        rem_q <= rem_d;
      end
      quo_q <= {quo_q[QuotW-2:0], fits};
      dvs_q <= dvs_q >> 1;
    end
  end

  assign status_o.p_gt_fire    = (p_q > LimFireTest);
  assign status_o.p_gt_diag    = (p_q > LimDiagHigh);
  assign status_o.p_lt_charged = (p_q < LimCharged);
  assign status_o.res_bad      = bad_q;

endmodule

[src/pras_seq.sv]
// Arming and firing sequence state, updated once per tick.
module pras_seq (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  pras_pkg::ctrl_cmd_t         cmd_i,
  input  pras_pkg::cfg_t              cfg_i,
  input  pras_pkg::arith_status_t     status_i,
  input  logic                        disarm_i,
  input  logic                        launch_i,
  output logic                        arm_gains_o,
  output logic                        fire_o,
  output logic                        charge_o,
  output logic                        diag_o,
  output logic                        led_o,
  output logic [pras_pkg::StatusW-1:0] status_code_o,
  output logic [pras_pkg::ModeW-1:0]  mode_o,
  output logic                        alarm_o,
  output logic                        res_warn_o
);
  import pras_pkg::*;

  typedef enum logic [ModeW-1:0] {
    ModeError   = 3'd0,
    ModeDisInit = 3'd1,
    ModeDisLoop = 3'd2,
    ModeArmInit = 3'd3,
    ModeArmLoop = 3'd4,
    ModeFired   = 3'd5
  } mode_e;

  mode_e              mode_q, mode_d;
  logic               fire_q, fire_d, charge_q, charge_d, diag_q, diag_d, led_q, led_d;
  logic [StatusW-1:0] stat_q, stat_d;
  logic               st_done_q, st_done_d;
  logic [TicksW-1:0]  ftc_q, ftc_d, dgc_q, dgc_d, chc_q, chc_d;
  logic               alarm_q, alarm_d, rwarn_q, rwarn_d;
  logic               disarm_q, launch_q;

  always_comb begin
    mode_d    = mode_q;
    fire_d    = fire_q;
    charge_d  = charge_q;
    diag_d    = diag_q;
    led_d     = led_q;
    stat_d    = stat_q;
    st_done_d = st_done_q;
    ftc_d     = ftc_q;
    dgc_d     = dgc_q;
    chc_d     = chc_q;
    alarm_d   = 1'b0;
    rwarn_d   = 1'b0;
    case (mode_q)
      ModeDisInit: begin
        led_d    = 1'b0;
        charge_d = 1'b0;
        fire_d   = 1'b0;
        stat_d   = StatusDisarmed;
        diag_d   = 1'b1;
        mode_d   = ModeDisLoop;
      end
      ModeDisLoop: begin
        if (!st_done_q) begin
          if (!fire_q) begin
            fire_d = 1'b1;
          end else if (status_i.p_gt_fire) begin
            ftc_d = ftc_q - 1'b1;
            if (ftc_d == '0) begin
              mode_d = ModeError;
            end
          end else begin
            ftc_d     = cfg_i.diag_fault_ticks;
            fire_d    = 1'b0;
            st_done_d = 1'b1;
          end
        end else if (status_i.res_bad || status_i.p_gt_diag) begin
          dgc_d = dgc_q - 1'b1;
          if (dgc_d == '0) begin
            mode_d = ModeError;
          end
        end else begin
          dgc_d = cfg_i.diag_fault_ticks;
          if (!disarm_q) begin
            mode_d = ModeArmInit;
          end
        end
      end
      ModeArmInit: begin
        diag_d   = 1'b0;
        led_d    = 1'b1;
        charge_d = 1'b1;
        stat_d   = StatusOk;
        mode_d   = ModeArmLoop;
      end
      ModeArmLoop: begin
        if (disarm_q) begin
          mode_d   = ModeDisInit;
          charge_d = 1'b0;
        end else begin
          // Charge counter is not reloaded at zero: keep wrapping while low
          if (status_i.p_lt_charged) begin
            chc_d = chc_q - 1'b1;
            if (chc_d == '0) begin
              alarm_d = 1'b1;
            end
          end else begin
            chc_d = cfg_i.charge_fault_ticks;
          end
          rwarn_d = status_i.res_bad;
          if (launch_q) begin
            fire_d = 1'b1;
            mode_d = ModeFired;
          end
        end
      end
      ModeFired: begin
        led_d = 1'b0;
        if (disarm_q) begin
          mode_d   = ModeDisInit;
          charge_d = 1'b0;
        end
      end
      ModeError: begin
        fire_d   = 1'b0;
        diag_d   = 1'b0;
        led_d    = 1'b0;
        charge_d = 1'b0;
        stat_d   = StatusFail;
      end
      default: begin
        mode_d = ModeError;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= ModeDisInit;
      fire_q    <= 1'b0;
      charge_q  <= 1'b0;
      diag_q    <= 1'b0;
      led_q     <= 1'b0;
      stat_q    <= StatusDisarmed;
      st_done_q <= 1'b0;
      ftc_q     <= RstDiagTicks;
      dgc_q     <= RstDiagTicks;
      chc_q     <= RstChrgTicks;
      alarm_q   <= 1'b0;
      rwarn_q   <= 1'b0;
    end else if (cmd_i.commit) begin
      mode_q    <= mode_d;
      fire_q    <= fire_d;
      charge_q  <= charge_d;
      diag_q    <= diag_d;
      led_q     <= led_d;
      stat_q    <= stat_d;
      st_done_q <= st_done_d;
      ftc_q     <= ftc_d;
      dgc_q     <= dgc_d;
      chc_q     <= chc_d;
      alarm_q   <= alarm_d;
      rwarn_q   <= rwarn_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      disarm_q <= disarm_i;
      launch_q <= launch_i;
    end
  end

  assign arm_gains_o   = (mode_q == ModeArmLoop);
  assign fire_o        = fire_q;
  assign charge_o      = charge_q;
  assign diag_o        = diag_q;
  assign led_o         = led_q;
  assign status_code_o = stat_q;
  assign mode_o        = mode_q;
  assign alarm_o       = alarm_q;
  assign res_warn_o    = rwarn_q;

endmodule

[src/pras_ctrl.sv]
// Controller: handshakes and step sequencing of one tick.
module pras_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output pras_pkg::ctrl_cmd_t cmd_o
);
  import pras_pkg::*;

  typedef enum logic [2:0] {
    StIdle,
    StMul,
    StScale,
    StSetup,
    StDiv,
    StCmp,
    StDone
  } state_e;

  state_e             state_q;
  logic [DivCntW-1:0] cnt_q;
  logic               out_valid_q;
  logic               slot_free;

  assign slot_free = !out_valid_q || out_ready_i;

  always_comb begin
    cmd_o          = '0;
    cmd_o.load     = (state_q == StIdle) && in_valid_i;
    cmd_o.mul      = (state_q == StMul);
    cmd_o.scale    = (state_q == StScale);
    cmd_o.setup    = (state_q == StSetup);
    cmd_o.div_step = (state_q == StDiv);
    cmd_o.cmp      = (state_q == StCmp);
    cmd_o.commit   = (state_q == StDone) && slot_free;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_o.commit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        StIdle: begin
          if (in_valid_i) begin
            state_q <= StMul;
          end
        end
        StMul:   state_q <= StScale;
        StScale: state_q <= StSetup;
        StSetup: begin
          cnt_q   <= DivCntW'(QuotW - 1);
          state_q <= StDiv;
        end
        StDiv: begin
          cnt_q <= cnt_q - 1'b1;
          if (cnt_q == '0) begin
            state_q <= StCmp;
          end
        end
        StCmp:   state_q <= StDone;
        StDone: begin
          if (slot_free) begin
            state_q <= StIdle;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  assign in_ready_o  = (state_q == StIdle);
  assign out_valid_o = out_valid_q;

endmodule

[src/pyro_recovery_arming_sequencer.sv]
// Top level of the pyro recovery arming sequencer.
//
//   channel  dir  handshake          beat contents
//   -------  ---  -----------------  ---------------------------------------------
//   in_i     in   valid/ready        squib_mv, pyro_mv, disarm_request, launch
//   out_o    out  valid/ready        drives, arm_led, status_code, mode_now, alarms
//   cfg      in   cfg_we_i (no wait) cfg_idx_i selects register, cfg_wdata_i value
//
// Each tick runs from the input beat through a multiply step for the gained voltages, a
// step for the resistance scale, a setup step, the restoring divider (one quotient bit
// a cycle), a compare step and a commit step; the result beat is offered from the
// cycle after commit.
// The next input beat is also taken in the cycle after commit; a waiting result beat
// sits in its output register and holds the controller in its commit state only once
// the next tick has finished.
// Reset is asynchronous, active low, and loads the register reset values; no
// clearing pass is needed.
module pyro_recovery_arming_sequencer (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [pras_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [pras_pkg::CfgDataW-1:0]  cfg_wdata_i,
  pras_in_if.sink                        in_i,
  pras_out_if.source                     out_o
);
  import pras_pkg::*;

  cfg_t          cfg;
  ctrl_cmd_t     cmd;
  arith_status_t arith_st;
  logic          arm_gains;

  // Register file; the user must write it only while no tick is in flight, the block does not enforce this
  pras_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  // Sequence the steps of a tick and own both handshakes
  pras_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .cmd_o       (cmd)
  );

  // Gained voltages, limit flags and squib resistance check
  pras_arith u_arith (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .cfg_i       (cfg),
    .arm_gains_i (arm_gains),
    .squib_mv_i  (in_i.squib_mv),
    .pyro_mv_i   (in_i.pyro_mv),
    .status_o    (arith_st)
  );

  // Mode sequence; its output registers are the result beat and advance only at commit
  pras_seq u_seq (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .cfg_i         (cfg),
    .status_i      (arith_st),
    .disarm_i      (in_i.disarm_request),
    .launch_i      (in_i.launch),
    .arm_gains_o   (arm_gains),
    .fire_o        (out_o.fire_drive),
    .charge_o      (out_o.charge_drive),
    .diag_o        (out_o.diag_drive),
    .led_o         (out_o.arm_led),
    .status_code_o (out_o.status_code),
    .mode_o        (out_o.mode_now),
    .alarm_o       (out_o.charge_low_alarm),
    .res_warn_o    (out_o.resistance_warning)
  );

endmodule
